// ===== sv/swqp_pkg.sv =====
// Shared types and constants for the smooth weighted quota picker.
// No dependencies; imported by every module of the block.
package swqp_pkg;

    localparam int SOURCES  = 8;
    localparam int SRC_W    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int SLOT_W   = 3;
    localparam int ACTION_W = 2;
    localparam int WEIGHT_W = 16;
    localparam int QUOTA_W  = 16;
    localparam int CREDIT_W = 32;
    localparam int LIMIT_W  = 16;
    localparam int PICKS_W  = 16;
    localparam int SRC_OUT_W = 3;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PICK  = 2'd2;

    localparam logic [CREDIT_W:0]   ONE_CREDIT       = 33'd256;
    localparam logic [LIMIT_W-1:0]  PICK_LIMIT_RESET = 16'd64;
    localparam logic [CREDIT_W-1:0] CREDIT_MAX       = 32'h7FFF_FFFF;
    localparam logic [CREDIT_W-1:0] CREDIT_MIN       = 32'h8000_0000;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [CREDIT_W-1:0] credit;
        logic [QUOTA_W-1:0]  quota;
        logic [QUOTA_W-1:0]  taken;
    } t_entry;

    typedef struct packed {
        logic             clr;
        logic             we;
        logic [SRC_W-1:0] waddr;
        t_entry           wdata;
    } t_tbl_wr;

    typedef enum logic {
        ALU_ADD_W,
        ALU_SUB_ONE
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [CREDIT_W-1:0] credit;
        logic [WEIGHT_W-1:0] weight;
        logic [CREDIT_W-1:0] ref_credit;
    } t_alu_req;

    typedef struct packed {
        logic [CREDIT_W-1:0] credit;
        logic                gt;
    } t_alu_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH,
        ST_EMIT
    } t_state;

endpackage

// ===== sv/smooth_weighted_quota_picker.sv =====
// Top level of the smooth weighted quota picker: sequencer, pick counter,
// limit register and output register. Uses swqp_pkg, swqp_tbl, swqp_alu.
//
//  channel   dir  handshake                     contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   action, slot, weight, quota
//  m_axis    out  m_axis_tvalid/m_axis_tready   found, chosen source, sample index
//  cfg       in   i_cfg_valid/o_cfg_ready       pick_limit
//
// Clear and set are applied in ST_IDLE. A pick walks the table one source per cycle
// through the shared credit unit; when the limit is already reached it skips the
// walk and goes straight to ST_EMIT.
// Reset is synchronous and clears the whole table at once.
// A result waits in the output register; a new one stalls only in ST_EMIT.
module smooth_weighted_quota_picker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [2:0] source_slot, [18:3] weight_in, [34:19] quota_in, rest zero
    input  logic [swqp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [1:0] action
    input  logic [swqp_pkg::ACTION_W-1:0]         s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [2:0] chosen_source, [18:3] sample_index, rest zero
    output logic [swqp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] found
    output logic                                  m_axis_tuser,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [swqp_pkg::LIMIT_W-1:0]          i_cfg_data
);
    import swqp_pkg::*;

    t_state              r_state, n_state;
    logic [SRC_W-1:0]    r_idx, n_idx;
    logic [SRC_W-1:0]    r_best, n_best;
    logic                r_have, n_have;
    logic [CREDIT_W-1:0] r_lead_credit, n_lead_credit;
    logic [PICKS_W-1:0]  r_picks, n_picks;
    logic [LIMIT_W-1:0]  r_limit;
    logic                r_res_found, n_res_found;
    logic [SRC_W-1:0]    r_res_src, n_res_src;
    logic [QUOTA_W-1:0]  r_res_sample, n_res_sample;
    logic                r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic                r_out_tuser, n_out_tuser;

    logic                in_acc;
    logic [SLOT_W-1:0]   in_slot;
    logic [WEIGHT_W-1:0] in_weight;
    logic [QUOTA_W-1:0]  in_quota;
    logic                slot_ok;
    logic [SRC_W-1:0]    raddr;
    t_entry              entry;
    logic                active;
    t_tbl_wr             tbl_wr;
    t_alu_req            alu_req;
    t_alu_rsp            alu_rsp;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign in_slot   = s_axis_tdata[2:0];
    assign in_weight = s_axis_tdata[18:3];
    assign in_quota  = s_axis_tdata[34:19];
    assign slot_ok   = 32'(in_slot) < SOURCES;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;
    assign s_axis_tready = (r_state == ST_IDLE);

    assign raddr  = (r_state == ST_FINISH) ? r_best : r_idx;
    assign active = entry.taken < entry.quota;

    swqp_tbl u_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (raddr),
        .o_rdata (entry),
        .i_wr    (tbl_wr)
    );

    swqp_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_comb begin
        alu_req.op         = (r_state == ST_FINISH) ? ALU_SUB_ONE : ALU_ADD_W;
        alu_req.credit     = entry.credit;
        alu_req.weight     = entry.weight;
        alu_req.ref_credit = r_lead_credit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_picks     <= '0;
            r_limit     <= PICK_LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_have      <= n_have;
            r_picks     <= n_picks;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_best        <= n_best;
        r_lead_credit <= n_lead_credit;
        r_res_found   <= n_res_found;
        r_res_src     <= n_res_src;
        r_res_sample  <= n_res_sample;
        r_out_tdata   <= n_out_tdata;
        r_out_tuser   <= n_out_tuser;
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_best        = r_best;
        n_have        = r_have;
        n_lead_credit = r_lead_credit;
        n_picks       = r_picks;
        n_res_found   = r_res_found;
        n_res_src     = r_res_src;
        n_res_sample  = r_res_sample;
        n_out_valid   = r_out_valid;
        n_out_tdata   = r_out_tdata;
        n_out_tuser   = r_out_tuser;
        tbl_wr.clr    = 1'b0;
        tbl_wr.we     = 1'b0;
        tbl_wr.waddr  = r_idx;
        tbl_wr.wdata  = entry;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_axis_tuser)
                        ACT_CLEAR: begin
                            tbl_wr.clr = 1'b1;
                            n_picks    = '0;
                        end
                        ACT_SET: begin
                            if (slot_ok) begin
                                tbl_wr.we           = 1'b1;
                                tbl_wr.waddr        = SRC_W'(in_slot);
                                tbl_wr.wdata.weight = in_weight;
                                tbl_wr.wdata.credit = '0;
                                tbl_wr.wdata.quota  = in_quota;
                                tbl_wr.wdata.taken  = '0;
                            end
                        end
                        ACT_PICK: begin
                            if (r_picks >= r_limit) begin
                                n_res_found  = 1'b0;
                                n_res_src    = '0;
                                n_res_sample = '0;
                                n_state      = ST_EMIT;
                            end else begin
                                n_idx   = '0;
                                n_have  = 1'b0;
                                n_state = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (active) begin
                    tbl_wr.we           = 1'b1;
                    tbl_wr.wdata.credit = alu_rsp.credit;
                    if (!r_have || alu_rsp.gt) begin
                        n_best        = r_idx;
                        n_lead_credit = alu_rsp.credit;
                        n_have        = 1'b1;
                    end
                end
                if (r_idx == SRC_W'(SOURCES - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_FINISH: begin
                if (r_have) begin
                    tbl_wr.we           = 1'b1;
                    tbl_wr.waddr        = r_best;
                    tbl_wr.wdata.credit = alu_rsp.credit;
                    tbl_wr.wdata.taken  = entry.taken + 1'b1;
                    n_picks             = r_picks + 1'b1;
                    n_res_found         = 1'b1;
                    n_res_src           = r_best;
                    n_res_sample        = entry.taken;
                end else begin
                    n_res_found  = 1'b0;
                    n_res_src    = '0;
                    n_res_sample = '0;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_tdata = {5'd0, r_res_sample, SRC_OUT_W'(r_res_src)};
                    n_out_tuser = r_res_found;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // pick at the limit reports not found and skips the walk
    a_limit_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == ACT_PICK && r_picks >= r_limit)
        |=> (r_state == ST_EMIT && !r_res_found))
        else $error("limit-reached pick did not go straight to emit");

    // no winner means the pick count holds
    a_no_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && !r_have) |=> $stable(r_picks))
        else $error("pick count moved without a winner");

    // saturating add of a weight never lowers a credit
    a_add_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && active)
        |-> !($signed(alu_rsp.credit) < $signed(entry.credit)))
        else $error("credit decreased on weight add");

    // a winning pick advances the pick count by one
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_have) |=> (r_picks == $past(r_picks) + 1'b1))
        else $error("pick count not advanced on a winning pick");

endmodule

// ===== sv/swqp_tbl.sv =====
// Source table: weight, credit, quota and taken count per source, in flops.
// One read port, one write port, clear of the whole table at once. Depends on swqp_pkg.
module swqp_tbl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [swqp_pkg::SRC_W-1:0]  i_raddr,
    output swqp_pkg::t_entry            o_rdata,
    input  swqp_pkg::t_tbl_wr           i_wr
);
    import swqp_pkg::*;

    t_entry r_tbl [SOURCES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clr) begin
            for (int i = 0; i < SOURCES; i++) begin
                r_tbl[i] <= '0;
            end
        end else if (i_wr.we) begin
            r_tbl[i_wr.waddr] <= i_wr.wdata;
        end
    end

    assign o_rdata = r_tbl[i_raddr];

endmodule

// ===== sv/swqp_alu.sv =====
// Shared credit unit: saturating add of a weight or removal of 1.0,
// plus signed compare against the running best. Depends on swqp_pkg.
module swqp_alu (
    input  swqp_pkg::t_alu_req i_req,
    output swqp_pkg::t_alu_rsp o_rsp
);
    import swqp_pkg::*;

    logic [CREDIT_W:0]   sum;
    logic [CREDIT_W:0]   operand;
    logic [CREDIT_W-1:0] sat;

    always_comb begin
        operand = (i_req.op == ALU_ADD_W) ? (CREDIT_W+1)'(i_req.weight) : ONE_CREDIT;
        if (i_req.op == ALU_ADD_W) begin
            sum = {i_req.credit[CREDIT_W-1], i_req.credit} + operand;
        end else begin
            sum = {i_req.credit[CREDIT_W-1], i_req.credit} - operand;
        end
        if (sum[CREDIT_W] != sum[CREDIT_W-1]) begin
            sat = sum[CREDIT_W] ? CREDIT_MIN : CREDIT_MAX;
        end else begin
            sat = sum[CREDIT_W-1:0];
        end
        o_rsp.credit = sat;
        o_rsp.gt     = $signed(sat) > $signed(i_req.ref_credit);
    end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for smooth_weighted_quota_picker: directed and random
// transactions, with a transaction-level credit/quota predictor and an in-order result check.
// Depends on swqp_pkg and the smooth_weighted_quota_picker RTL.
module testbench;
    import swqp_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 2 * SOURCES + 8;
    localparam int HEAVY_PICKS    = 30;
    localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

    typedef struct packed {
        logic                 found;
        logic [SRC_OUT_W-1:0] source;
        logic [PICKS_W-1:0]   sample;
    } t_pick_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [ACTION_W-1:0]    s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [LIMIT_W-1:0]     i_cfg_data;

    // predictor state
    logic [WEIGHT_W-1:0]        weight_tbl [SOURCES];
    logic signed [CREDIT_W-1:0] credit_tbl [SOURCES];
    logic [QUOTA_W-1:0]         quota_tbl  [SOURCES];
    logic [QUOTA_W-1:0]         taken_tbl  [SOURCES];
    logic [PICKS_W-1:0]         picks_granted;
    logic [LIMIT_W-1:0]         limit_reg;

    t_pick_result pending_picks [$];
    int mismatches;
    int items_sent;
    int send_idle_pct;
    int ready_stall_pct;
    int idle_cycles;

    smooth_weighted_quota_picker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    task automatic clear_source_table();
        int i;
        for (i = 0; i < SOURCES; i++) begin
            weight_tbl[i] = '0;
            credit_tbl[i] = '0;
            quota_tbl[i]  = '0;
            taken_tbl[i]  = '0;
        end
        picks_granted = '0;
    endtask

    // Applies one transaction to the predictor; a pick queues its expected result.
    task automatic predict_transaction(input logic [ACTION_W-1:0] act,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [WEIGHT_W-1:0] w,
                                       input logic [QUOTA_W-1:0] q);
        int i;
        int best;
        logic signed [CREDIT_W-1:0] lead_credit;
        longint sum;
        t_pick_result res;
        case (act)
            ACT_CLEAR: begin
                clear_source_table();
            end
            ACT_SET: begin
                if (slot < SOURCES) begin
                    weight_tbl[slot] = w;
                    quota_tbl[slot]  = q;
                    credit_tbl[slot] = '0;
                    taken_tbl[slot]  = '0;
                end
            end
            ACT_PICK: begin
                res = '0;
                best = -1;
                lead_credit = '0;
                if (picks_granted < limit_reg) begin
                    for (i = 0; i < SOURCES; i++) begin
                        if (taken_tbl[i] < quota_tbl[i]) begin
                            sum = longint'(credit_tbl[i]) + longint'(weight_tbl[i]);
                            if (sum > 64'sh7FFF_FFFF)
                                credit_tbl[i] = 32'sh7FFF_FFFF;
                            else
                                credit_tbl[i] = sum[CREDIT_W-1:0];
                            if (best < 0 || credit_tbl[i] > lead_credit) begin
                                lead_credit = credit_tbl[i];
                                best = i;
                            end
                        end
                    end
                    if (best >= 0) begin
                        sum = longint'(credit_tbl[best]) - 64'sd256;
                        if (sum < -64'sd2147483648)
                            credit_tbl[best] = 32'sh8000_0000;
                        else
                            credit_tbl[best] = sum[CREDIT_W-1:0];
                        res.found  = 1'b1;
                        res.source = best[SRC_OUT_W-1:0];
                        res.sample = taken_tbl[best];
                        taken_tbl[best] = taken_tbl[best] + 1'b1;
                        picks_granted = picks_granted + 1'b1;
                    end
                end
                pending_picks.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] slot,
                             input logic [WEIGHT_W-1:0] w, input logic [QUOTA_W-1:0] q);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(IN_TDATA_W-35){1'b0}}, q, w, slot};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_transaction(act, slot, w, q);
        if (act != ACT_IGNORED)
            items_sent++;
    endtask

    task automatic send_pick();
        send_item(ACT_PICK, SLOT_W'($urandom), WEIGHT_W'($urandom), QUOTA_W'($urandom));
    endtask

    task automatic send_clear();
        send_item(ACT_CLEAR, SLOT_W'($urandom), WEIGHT_W'($urandom), QUOTA_W'($urandom));
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pick_limit(input logic [LIMIT_W-1:0] value);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        limit_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3, 4, 5: return WEIGHT_W'($urandom_range(1, 1024));
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic logic [QUOTA_W-1:0] rand_quota();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'hFFFF;
            8, 9:    return QUOTA_W'($urandom);
            default: return QUOTA_W'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic test_reset_limit();
        send_clear();
        send_item(ACT_SET, 3'd6, 16'h0100, 16'hFFFF);
        repeat (int'(PICK_LIMIT_RESET) + 2) send_pick();
    endtask

    task automatic test_directed_cases();
        write_pick_limit(16'hFFFF);
        send_clear();
        send_pick();
        send_item(ACT_IGNORED, SLOT_W'($urandom), WEIGHT_W'($urandom), QUOTA_W'($urandom));
        send_item(ACT_SET, 3'd0, 16'h0000, 16'hFFFF);
        send_item(ACT_SET, 3'd7, 16'hFFFF, 16'h0001);
        send_item(ACT_SET, 3'd3, 16'h0100, 16'h0000);
        send_item(ACT_SET, 3'd1, 16'h0100, 16'h0002);
        send_item(ACT_SET, 3'd2, 16'h0100, 16'h0002);
        repeat (6) send_pick();
        send_clear();
        send_pick();
        send_item(ACT_SET, 3'd5, 16'h0080, 16'h0003);
        send_item(ACT_IGNORED, SLOT_W'($urandom), WEIGHT_W'($urandom), QUOTA_W'($urandom));
        repeat (4) send_pick();
    endtask

    task automatic test_limit_extremes();
        write_pick_limit(16'd1);
        send_clear();
        send_item(ACT_SET, 3'd4, 16'h0200, 16'd10);
        send_pick();
        send_pick();
        write_pick_limit(16'd0);
        send_pick();
        write_pick_limit(16'hFFFF);
        send_pick();
    endtask

    // Two full-weight sources build large credits back to back.
    task automatic test_heavy_weights();
        send_idle_pct = 0;
        ready_stall_pct = 0;
        write_pick_limit(16'hFFFF);
        send_clear();
        send_item(ACT_SET, 3'd0, 16'hFFFF, 16'hFFFF);
        send_item(ACT_SET, 3'd1, 16'hFFFF, 16'hFFFF);
        repeat (HEAVY_PICKS) send_pick();
        send_clear();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [LIMIT_W-1:0] limit, input int n_items);
        int start;
        int n;
        start = items_sent;
        send_idle_pct = idle_pct;
        ready_stall_pct = stall_pct;
        write_pick_limit(limit);
        while (items_sent - start < n_items) begin
            if ($urandom_range(99) < 70) begin
                if ($urandom_range(1))
                    send_clear();
                n = $urandom_range(1, SOURCES);
                repeat (n) send_item(ACT_SET, SLOT_W'($urandom), rand_weight(), rand_quota());
                n = $urandom_range(1, 40);
                repeat (n) begin
                    if ($urandom_range(99) < 5)
                        send_item($urandom_range(1) ? ACT_IGNORED : ACT_SET,
                                  SLOT_W'($urandom), rand_weight(), rand_quota());
                    send_pick();
                end
            end else begin
                send_item(ACTION_W'($urandom), SLOT_W'($urandom), rand_weight(),
                          rand_quota());
            end
        end
    endtask

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);

    always @(posedge i_clk) begin : check_results
        t_pick_result exp_res;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_picks.size() == 0) begin
                $error("unexpected result: found=%0d source=%0d sample_index=%0d",
                       m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[18:3]);
                mismatches++;
            end else begin
                exp_res = pending_picks.pop_front();
                if (m_axis_tuser !== exp_res.found) begin
                    $error("found: expected %0d, got %0d", exp_res.found, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[2:0] !== exp_res.source) begin
                    $error("chosen_source: expected %0d, got %0d",
                           exp_res.source, m_axis_tdata[2:0]);
                    mismatches++;
                end
                if (m_axis_tdata[18:3] !== exp_res.sample) begin
                    $error("sample_index: expected %0d, got %0d",
                           exp_res.sample, m_axis_tdata[18:3]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("smooth_weighted_quota_picker verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = ACT_CLEAR;
        m_axis_tready   = 1'b1;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        mismatches      = 0;
        items_sent      = 0;
        idle_cycles     = 0;
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        clear_source_table();
        limit_reg = PICK_LIMIT_RESET;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_limit();
        test_directed_cases();
        test_limit_extremes();
        test_heavy_weights();
        test_random_traffic(0, 0, 16'hFFFF, 140);
        test_random_traffic(80, 0, LIMIT_W'($urandom_range(20, 80)), 140);
        test_random_traffic(0, 80, LIMIT_W'($urandom_range(1, 65535)), 140);
        test_random_traffic(20, 20, LIMIT_W'($urandom_range(5, 30)), 140);
        wait_quiet();

        if (mismatches == 0)
            $display("smooth_weighted_quota_picker verification clean");
        else
            $display("smooth_weighted_quota_picker verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/swqp_pkg.sv
sv/swqp_tbl.sv
sv/swqp_alu.sv
sv/smooth_weighted_quota_picker.sv
sim/testbench.sv
